### rtl/mse_pkg.sv
package mse_pkg;

    localparam int unsigned MEM_BYTES_DEF = 4096;

    localparam logic [4:0] OP_ADD   = 5'd0;
    localparam logic [4:0] OP_ADDI  = 5'd1;
    localparam logic [4:0] OP_ADDIU = 5'd2;
    localparam logic [4:0] OP_ANDI  = 5'd3;
    localparam logic [4:0] OP_AND   = 5'd4;
    localparam logic [4:0] OP_BEQ   = 5'd5;
    localparam logic [4:0] OP_BNE   = 5'd6;
    localparam logic [4:0] OP_DIV   = 5'd7;
    localparam logic [4:0] OP_JAL   = 5'd8;
    localparam logic [4:0] OP_JR    = 5'd9;
    localparam logic [4:0] OP_J     = 5'd10;
    localparam logic [4:0] OP_LBU   = 5'd11;
    localparam logic [4:0] OP_LH    = 5'd12;
    localparam logic [4:0] OP_LUI   = 5'd13;
    localparam logic [4:0] OP_LW    = 5'd14;
    localparam logic [4:0] OP_MULT  = 5'd15;
    localparam logic [4:0] OP_MFHI  = 5'd16;
    localparam logic [4:0] OP_MFLO  = 5'd17;
    localparam logic [4:0] OP_ORI   = 5'd18;
    localparam logic [4:0] OP_OR    = 5'd19;
    localparam logic [4:0] OP_SB    = 5'd20;
    localparam logic [4:0] OP_SH    = 5'd21;
    localparam logic [4:0] OP_SRL   = 5'd22;
    localparam logic [4:0] OP_SUB   = 5'd23;
    localparam logic [4:0] OP_SW    = 5'd24;
    localparam logic [4:0] OP_SLL   = 5'd25;
    localparam logic [4:0] OP_SLTI  = 5'd26;
    localparam logic [4:0] OP_SLT   = 5'd27;

    typedef struct packed {
        logic [4:0]         action;
        logic [4:0]         target_reg;
        logic [4:0]         first_reg;
        logic [4:0]         second_reg;
        logic signed [31:0] immediate;
        logic [25:0]        jump_index;
    } t_in_beat;

    typedef struct packed {
        logic [31:0]        next_pc;
        logic               write_enable;
        logic [4:0]         write_index;
        logic signed [31:0] write_value;
        logic               status;
    } t_out_beat;

endpackage

### rtl/mips_subset_execute.sv
// ALU, branch, jump and divide-by-zero instructions read operands and execute; a store
// adds a write per byte, a load a read and a collect per byte; mult and div add their states.
// Only one instruction is in flight at a time; the next beat can be taken in the cycle
// after the result beat is loaded, and loading waits while an earlier result is stalled.
// Reset (synchronous, active low) clears PC, HI and LO at once, then sweeps
// the register file (overlapped with the memory sweep) and data memory
// to zero; no beat is accepted until the sweep ends.
module mips_subset_execute #(
    parameter int unsigned MEM_BYTES = mse_pkg::MEM_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  mse_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output mse_pkg::t_out_beat o_out_data
);
    import mse_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);

    // States of the sequencer.
    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RA    = 4'd2;  // first register read returns
    localparam logic [3:0] S_RB    = 4'd3;  // second read returns
    localparam logic [3:0] S_RT    = 4'd4;  // third read returns
    localparam logic [3:0] S_MEM   = 4'd5;  // byte loop over memory
    localparam logic [3:0] S_MUL   = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_EXE   = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;
    localparam logic [3:0] S_MULH  = 4'd10;

    // Register file (read and write ports) and byte-wide data memory (one port), synchronous.
    logic [31:0] r_rf [0:31];
    logic [7:0]  r_dm [0:MEM_BYTES-1];
    logic [31:0] r_rf_q;
    logic [7:0]  r_dm_q;

    logic [3:0]  r_st;
    logic [AW:0] r_clr;
    t_in_beat    r_ins;
    logic [31:0] r_pc, r_hi, r_lo, r_a, r_b, r_t, r_acc;
    logic [2:0]  r_bi;          // byte index within a memory access
    logic        r_bph;         // memory phase: 0 issue read, 1 take data
    logic [5:0]  r_cnt;
    logic [31:0] r_rem, r_quo, r_ud;
    logic        r_sn, r_sd;
    logic [31:0] r_pll, r_plh, r_phl, r_phh;
    t_out_beat   r_res;         // finished beat waiting for the output register
    t_out_beat   r_out;
    logic        r_ov;

    // Register file and data memory port control.
    logic        rf_we;
    logic [4:0]  rf_wa, rf_ra;
    logic [31:0] rf_wd;
    logic        dm_we;
    logic [AW-1:0] dm_a;
    logic [7:0]  dm_wd;

    logic [4:0]  op;
    logic [31:0] imm, ea, res, npc;
    logic        wen, isld, isst;
    logic [2:0]  nbytes;
    logic [32:0] dsub;

    assign op   = r_ins.action;
    assign imm  = r_ins.immediate;
    assign ea   = imm + r_b;
    assign isld = (op == OP_LBU) || (op == OP_LH) || (op == OP_LW);
    assign isst = (op == OP_SB) || (op == OP_SH) || (op == OP_SW);
    always_comb begin
        case (op)
            OP_LBU, OP_SB: nbytes = 3'd1;
            OP_LH, OP_SH:  nbytes = 3'd2;
            default:       nbytes = 3'd4;
        endcase
    end

    assign o_in_stall  = (r_st != S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    // Result and next PC from the collected operands.
    always_comb begin
        res = 32'd0;
        wen = 1'b1;
        npc = r_pc + 32'd4;
        case (op)
            OP_ADD:           res = r_a + r_b;
            OP_ADDI, OP_ADDIU: res = r_a + imm;
            OP_ANDI:          res = r_a & imm;
            OP_AND:           res = r_a & r_b;
            OP_BEQ: begin
                wen = 1'b0;
                if (r_t == r_a) npc = r_pc + {imm[29:0], 2'b00};
            end
            OP_BNE: begin
                wen = 1'b0;
                if (r_t != r_a) npc = r_pc + {imm[29:0], 2'b00};
            end
            OP_JAL: begin
                res = r_pc + 32'd4;
                npc = {r_pc[31:28], r_ins.jump_index, 2'b00};
            end
            OP_J: begin
                wen = 1'b0;
                npc = {r_pc[31:28], r_ins.jump_index, 2'b00};
            end
            OP_JR: begin
                wen = 1'b0;
                npc = r_a;
            end
            OP_LBU:  res = {24'd0, r_acc[7:0]};
            OP_LH:   res = {{16{r_acc[15]}}, r_acc[15:0]};
            OP_LW:   res = r_acc;
            OP_LUI:  res = {imm[15:0], 16'd0};
            OP_MFHI: res = r_hi;
            OP_MFLO: res = r_lo;
            OP_ORI:  res = r_a | imm;
            OP_OR:   res = r_a | r_b;
            OP_SRL:  res = r_a >> imm[4:0];
            OP_SUB:  res = r_a - r_b;
            OP_SLL:  res = r_a << imm[4:0];
            OP_SLTI: res = {31'd0, $signed(r_a) < $signed(imm)};
            OP_SLT:  res = {31'd0, $signed(r_a) < $signed(r_b)};
            default: wen = 1'b0;
        endcase
    end

    assign dsub = {r_rem[30:0], r_quo[31]} - {1'b0, r_ud};

    always_comb begin
        rf_we = 1'b0;
        rf_wa = r_clr[4:0];
        rf_wd = 32'd0;
        rf_ra = r_ins.first_reg;
        dm_we = 1'b0;
        dm_a  = r_clr[AW-1:0];
        dm_wd = 8'd0;
        case (r_st)
            S_CLR: begin
                rf_we = (r_clr < (AW+1)'(32));
                dm_we = 1'b1;
            end
            // The first read is issued at the edge that takes the beat.
            S_IDLE: rf_ra = i_in_data.first_reg;
            S_RA: rf_ra = r_ins.second_reg;
            S_RB: rf_ra = r_ins.target_reg;
            S_MEM: begin
                dm_a  = AW'(ea + 32'(r_bi));
                dm_we = isst;
                dm_wd = r_t[8*r_bi[1:0] +: 8];
            end
            S_EXE: begin
                rf_wa = (op == OP_JAL) ? 5'd31 : r_ins.target_reg;
                rf_wd = res;
                rf_we = wen && (rf_wa != 5'd0);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rf_we) r_rf[rf_wa] <= rf_wd;
        r_rf_q <= r_rf[rf_ra];
        if (dm_we) r_dm[dm_a] <= dm_wd;
        r_dm_q <= r_dm[dm_a];
    end

    // Sequencer. Register reads are issued one per cycle; r0 is never written
    // so it always reads as zero after the clearing sweep.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= S_CLR;
            r_clr <= '0;
            r_pc  <= '0;
            r_hi  <= '0;
            r_lo  <= '0;
            r_ov  <= 1'b0;
        end else begin
            if (r_st == S_OUT && (!r_ov || !i_out_stall)) r_ov <= 1'b1;
            else if (r_ov && !i_out_stall)                 r_ov <= 1'b0;
            case (r_st)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (AW+1)'(MEM_BYTES - 1)) r_st <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_ins <= i_in_data;
                        r_st  <= S_RA;
                    end
                end
                S_RA: begin
                    r_a  <= r_rf_q;
                    r_st <= S_RB;
                end
                S_RB: begin
                    r_b  <= r_rf_q;
                    r_st <= S_RT;
                end
                S_RT: begin
                    r_t   <= r_rf_q;
                    r_bi  <= '0;
                    r_bph <= 1'b0;
                    r_acc <= '0;
                    if (isld || isst) begin
                        r_st <= S_MEM;
                    end else if (op == OP_MULT) begin
                        r_st <= S_MUL;
                    end else if (op == OP_DIV) begin
                        r_sn  <= r_rf_q[31];
                        r_sd  <= r_a[31];
                        r_quo <= r_rf_q[31] ? 32'd0 - r_rf_q : r_rf_q;
                        r_ud  <= r_a[31] ? 32'd0 - r_a : r_a;
                        r_rem <= '0;
                        r_cnt <= '0;
                        r_st  <= (r_a == 32'd0) ? S_EXE : S_DIV;
                    end else begin
                        r_st <= S_EXE;
                    end
                end
                S_MEM: begin
                    // Stores write one byte a cycle; loads read then collect.
                    if (isst) begin
                        r_bi <= r_bi + 3'd1;
                        if (r_bi + 3'd1 == nbytes) r_st <= S_EXE;
                    end else if (!r_bph) begin
                        r_bph <= 1'b1;
                    end else begin
                        r_acc[8*r_bi[1:0] +: 8] <= r_dm_q;
                        r_bph <= 1'b0;
                        r_bi  <= r_bi + 3'd1;
                        if (r_bi + 3'd1 == nbytes) r_st <= S_EXE;
                    end
                end
                S_MUL: begin
                    // Sign and magnitudes for the four 16x16 partial products.
                    r_sn  <= r_a[31] ^ r_b[31];
                    r_ud  <= r_a[31] ? 32'd0 - r_a : r_a;
                    r_quo <= r_b[31] ? 32'd0 - r_b : r_b;
                    r_st  <= S_MULH;
                    r_cnt <= '0;
                end
                S_MULH: begin
                    if (r_cnt == 6'd0) begin
                        r_pll <= r_ud[15:0]  * r_quo[15:0];
                        r_plh <= r_ud[15:0]  * r_quo[31:16];
                        r_phl <= r_ud[31:16] * r_quo[15:0];
                        r_phh <= r_ud[31:16] * r_quo[31:16];
                        r_cnt <= 6'd1;
                    end else begin
                        logic [63:0] p;
                        p = {32'd0, r_pll} + {16'd0, r_plh, 16'd0}
                            + {16'd0, r_phl, 16'd0} + {r_phh, 32'd0};
                        if (r_sn) p = 64'd0 - p;
                        r_hi <= p[63:32];
                        r_lo <= p[31:0];
                        r_st <= S_EXE;
                    end
                end
                S_DIV: begin
                    // Restoring division, one quotient bit a cycle.
                    if (!dsub[32]) r_rem <= dsub[31:0];
                    else           r_rem <= {r_rem[30:0], r_quo[31]};
                    r_quo <= {r_quo[30:0], ~dsub[32]};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd31) r_st <= S_EXE;
                end
                S_EXE: begin
                    if (op == OP_DIV) begin
                        if (r_a == 32'd0) begin
                            r_lo <= 32'hFFFF_FFFF;
                            r_hi <= r_t;
                        end else begin
                            r_lo <= (r_sn != r_sd) ? 32'd0 - r_quo : r_quo;
                            r_hi <= r_sn ? 32'd0 - r_rem : r_rem;
                        end
                    end
                    r_st <= S_OUT;
                    r_pc <= npc;
                    r_res.next_pc <= npc;
                    r_res.status  <= (op == OP_DIV) && (r_a == 32'd0);
                    if (rf_we) begin
                        r_res.write_enable <= 1'b1;
                        r_res.write_index  <= rf_wa;
                        r_res.write_value  <= rf_wd;
                    end else begin
                        r_res.write_enable <= 1'b0;
                        r_res.write_index  <= 5'd0;
                        r_res.write_value  <= 32'd0;
                    end
                end
                S_OUT: begin
                    // Hold the finished beat until the output register is free.
                    if (!r_ov || !i_out_stall) begin
                        r_out <= r_res;
                        r_st  <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

endmodule

### tb/mips_subset_execute_tb.sv
`timescale 1ns / 1ps

module mips_subset_execute_tb;
    import mse_pkg::*;

    localparam int unsigned MEM_SIZE   = MEM_BYTES_DEF;
    localparam int          CYCLE_CAP  = 600000;
    localparam int          DRAIN_WAIT = 60;

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_beat  in_data;
    logic      out_valid;
    logic      out_stall;
    t_out_beat out_data;

    mips_subset_execute #(
        .MEM_BYTES(MEM_SIZE)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    // Architectural state of the predicted machine. It advances once per
    // accepted input beat, in the order in which the beats were accepted.
    logic [31:0] arch_pc;
    logic [31:0] arch_gpr [32];
    logic [31:0] arch_hi;
    logic [31:0] arch_lo;
    logic [7:0]  arch_mem [MEM_SIZE];

    // Results that are owed by the block, oldest first.
    t_out_beat   owed_results [$];
    int          fail_count;
    int          beats_sent;
    int          results_seen;
    int          div_zero_seen;
    int          cycle_count;
    bit          quiet;     // when set, neither side inserts idle cycles
    int          stall_left;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [31:0] mem_fetch(logic [31:0] addr, int nbytes);
        logic [31:0] v;
        v = '0;
        for (int i = 0; i < nbytes; i++)
            v[8*i +: 8] = arch_mem[(addr + i) % MEM_SIZE];
        return v;
    endfunction

    function automatic void mem_store(logic [31:0] addr, logic [31:0] v, int nbytes);
        for (int i = 0; i < nbytes; i++)
            arch_mem[(addr + i) % MEM_SIZE] = v[8*i +: 8];
    endfunction

    // Runs one instruction on the predicted machine and returns the beat
    // that the block should produce for it.
    function automatic t_out_beat execute_instr(t_in_beat b);
        logic [31:0]        a, bv, t, imm, npc, ea, wval, un, ud, q, r;
        logic [4:0]         widx;
        logic               wen, st, sn, sd;
        logic signed [63:0] prod;
        t_out_beat          o;
        a    = arch_gpr[b.first_reg];
        bv   = arch_gpr[b.second_reg];
        t    = arch_gpr[b.target_reg];
        imm  = b.immediate;
        npc  = arch_pc + 32'd4;
        ea   = imm + bv;
        wen  = 1'b0;
        widx = b.target_reg;
        wval = '0;
        st   = 1'b0;
        case (b.action)
            OP_ADD:           begin wen = 1'b1; wval = a + bv; end
            OP_ADDI, OP_ADDIU: begin wen = 1'b1; wval = a + imm; end
            OP_ANDI:          begin wen = 1'b1; wval = a & imm; end
            OP_AND:           begin wen = 1'b1; wval = a & bv; end
            OP_BEQ:           if (t == a) npc = arch_pc + (imm << 2);
            OP_BNE:           if (t != a) npc = arch_pc + (imm << 2);
            OP_DIV: begin
                if (a == 32'd0) begin
                    arch_lo = 32'hFFFF_FFFF;
                    arch_hi = t;
                    st      = 1'b1;
                end else begin
                    sn = t[31];
                    sd = a[31];
                    un = sn ? -t : t;
                    ud = sd ? -a : a;
                    q  = un / ud;
                    r  = un % ud;
                    arch_lo = (sn != sd) ? -q : q;
                    arch_hi = sn ? -r : r;
                end
            end
            OP_JAL: begin
                wen  = 1'b1;
                widx = 5'd31;
                wval = arch_pc + 32'd4;
                npc  = (arch_pc & 32'hF000_0000) | {4'b0, b.jump_index, 2'b00};
            end
            OP_JR:   npc = a;
            OP_J:    npc = (arch_pc & 32'hF000_0000) | {4'b0, b.jump_index, 2'b00};
            OP_LBU:  begin wen = 1'b1; wval = mem_fetch(ea, 1) & 32'h0000_00FF; end
            OP_LH: begin
                wen  = 1'b1;
                wval = mem_fetch(ea, 2) & 32'h0000_FFFF;
                if (wval[15]) wval |= 32'hFFFF_0000;
            end
            OP_LUI:  begin wen = 1'b1; wval = (imm & 32'h0000_FFFF) << 16; end
            OP_LW:   begin wen = 1'b1; wval = mem_fetch(ea, 4); end
            OP_MULT: begin
                prod    = $signed({{32{a[31]}}, a}) * $signed({{32{bv[31]}}, bv});
                arch_hi = prod[63:32];
                arch_lo = prod[31:0];
            end
            OP_MFHI: begin wen = 1'b1; wval = arch_hi; end
            OP_MFLO: begin wen = 1'b1; wval = arch_lo; end
            OP_ORI:  begin wen = 1'b1; wval = a | imm; end
            OP_OR:   begin wen = 1'b1; wval = a | bv; end
            OP_SB:   mem_store(ea, t & 32'h0000_00FF, 1);
            OP_SH:   mem_store(ea, t & 32'h0000_FFFF, 2);
            OP_SRL:  begin wen = 1'b1; wval = a >> imm[4:0]; end
            OP_SUB:  begin wen = 1'b1; wval = a - bv; end
            OP_SW:   mem_store(ea, t, 4);
            OP_SLL:  begin wen = 1'b1; wval = a << imm[4:0]; end
            OP_SLTI: begin wen = 1'b1; wval = ($signed(a) < $signed(imm)) ? 32'd1 : 32'd0; end
            OP_SLT:  begin wen = 1'b1; wval = ($signed(a) < $signed(bv)) ? 32'd1 : 32'd0; end
            default: ;
        endcase
        // A write to r0 is dropped and reported as no write at all.
        if (wen && widx == 5'd0) wen = 1'b0;
        if (wen) begin
            arch_gpr[widx] = wval;
        end else begin
            widx = '0;
            wval = '0;
        end
        arch_gpr[0] = '0;
        arch_pc     = npc;
        o.next_pc      = npc;
        o.write_enable = wen;
        o.write_index  = widx;
        o.write_value  = wval;
        o.status       = st;
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Sending side
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int roll;
        if (quiet) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offers one beat and returns once the block has taken it. Valid is only
    // lowered when an idle gap precedes the beat, so that back-to-back beats
    // never see valid fall and rise within the same time step.
    task automatic send_instr(input t_in_beat b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        do @(posedge i_clk); while (in_stall);
        owed_results.insert(owed_results.size(), execute_instr(b));
        beats_sent++;
    endtask

    function automatic t_in_beat make_instr(logic [4:0] op, logic [4:0] rt, logic [4:0] rs,
                                            logic [4:0] rb, logic [31:0] imm,
                                            logic [25:0] jidx);
        t_in_beat b;
        b.action     = op;
        b.target_reg = rt;
        b.first_reg  = rs;
        b.second_reg = rb;
        b.immediate  = imm;
        b.jump_index = jidx;
        return b;
    endfunction

    // Register numbers lean towards a small pool so that results feed later
    // instructions, but every register is reachable.
    function automatic logic [4:0] pick_reg();
        if ($urandom_range(0, 3) != 0) return 5'($urandom_range(0, 7));
        return 5'($urandom_range(0, 31));
    endfunction

    function automatic logic [31:0] pick_imm();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3, 4:    return 32'($signed($urandom_range(0, 128)) - 64);
            default: return $urandom;
        endcase
    endfunction

    // Fully random instruction over all 32 action codes, unused ones included.
    function automatic t_in_beat any_instr();
        return make_instr(5'($urandom_range(0, 31)), pick_reg(), pick_reg(), pick_reg(),
                          pick_imm(), 26'($urandom));
    endfunction

    // ------------------------------------------------------------------
    // Receiving side: stall pattern and result checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (quiet || !i_rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else begin
            case ($urandom_range(0, 19))
                0:       begin out_stall <= 1'b1; stall_left <= $urandom_range(8, 40); end
                1, 2, 3: begin out_stall <= 1'b1; stall_left <= $urandom_range(0, 3); end
                default: begin out_stall <= 1'b0; stall_left <= $urandom_range(0, 4); end
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (owed_results.size() == 0) begin
                $display("%0t: result beat with none expected, got %p", $time, out_data);
                fail_count++;
            end else begin
                want = owed_results.pop_front();
                if (out_data.status) div_zero_seen++;
                if (out_data.next_pc !== want.next_pc) begin
                    $display("%0t: next_pc expected %h, got %h",
                             $time, want.next_pc, out_data.next_pc);
                    fail_count++;
                end
                if (out_data.write_enable !== want.write_enable) begin
                    $display("%0t: write_enable expected %b, got %b",
                             $time, want.write_enable, out_data.write_enable);
                    fail_count++;
                end
                if (out_data.write_index !== want.write_index) begin
                    $display("%0t: write_index expected %0d, got %0d",
                             $time, want.write_index, out_data.write_index);
                    fail_count++;
                end
                if (out_data.write_value !== want.write_value) begin
                    $display("%0t: write_value expected %h, got %h",
                             $time, want.write_value, out_data.write_value);
                    fail_count++;
                end
                if (out_data.status !== want.status) begin
                    $display("%0t: status expected %b, got %b",
                             $time, want.status, out_data.status);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: the reset sweep, the slowest instructions and the longest
    // stalls on both sides all fit well inside this many cycles.
    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_CAP) begin
            $display("%0t: run exceeded %0d cycles, %0d results still owed",
                     $time, CYCLE_CAP, owed_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Corner cases in a fixed order: wrapping arithmetic, every divide
    // corner, the full product, sub-word loads and stores including
    // unaligned and wrapping addresses, writes to r0, every kind of jump
    // and branch, and the unused action codes.
    task automatic test_directed();
        send_instr(make_instr(OP_LUI,   5'd1, 5'd0, 5'd0, 32'h0000_8000, '0));
        send_instr(make_instr(OP_ADDI,  5'd2, 5'd0, 5'd0, 32'hFFFF_FFFF, '0));
        send_instr(make_instr(OP_ORI,   5'd3, 5'd0, 5'd0, 32'h7FFF_FFFF, '0));
        send_instr(make_instr(OP_ADD,   5'd4, 5'd3, 5'd3, '0, '0));
        send_instr(make_instr(OP_SUB,   5'd5, 5'd1, 5'd3, '0, '0));
        send_instr(make_instr(OP_DIV,   5'd3, 5'd0, 5'd0, '0, '0));
        send_instr(make_instr(OP_MFHI,  5'd6, 5'd0, 5'd0, '0, '0));
        send_instr(make_instr(OP_MFLO,  5'd7, 5'd0, 5'd0, '0, '0));
        send_instr(make_instr(OP_DIV,   5'd1, 5'd2, 5'd0, '0, '0));
        send_instr(make_instr(OP_MFHI,  5'd6, 5'd0, 5'd0, '0, '0));
        send_instr(make_instr(OP_MULT,  5'd0, 5'd1, 5'd1, '0, '0));
        send_instr(make_instr(OP_MFLO,  5'd7, 5'd0, 5'd0, '0, '0));
        send_instr(make_instr(OP_SW,    5'd3, 5'd0, 5'd0, 32'd4094, '0));
        send_instr(make_instr(OP_SH,    5'd2, 5'd0, 5'd1, 32'h8000_0001, '0));
        send_instr(make_instr(OP_LW,    5'd8, 5'd0, 5'd0, 32'hFFFF_FFFE, '0));
        send_instr(make_instr(OP_LH,    5'd9, 5'd0, 5'd0, 32'd1, '0));
        send_instr(make_instr(OP_SB,    5'd2, 5'd0, 5'd0, 32'd7, '0));
        send_instr(make_instr(OP_LBU,   5'd10, 5'd0, 5'd0, 32'd7, '0));
        send_instr(make_instr(OP_ADD,   5'd0, 5'd3, 5'd3, '0, '0));
        send_instr(make_instr(OP_SRL,   5'd11, 5'd2, 5'd0, 32'd31, '0));
        send_instr(make_instr(OP_SLL,   5'd12, 5'd2, 5'd0, 32'hFFFF_FFFF, '0));
        send_instr(make_instr(OP_SLTI,  5'd13, 5'd1, 5'd0, 32'h7FFF_FFFF, '0));
        send_instr(make_instr(OP_SLT,   5'd14, 5'd3, 5'd1, '0, '0));
        send_instr(make_instr(OP_ANDI,  5'd15, 5'd2, 5'd0, 32'hF0F0_F0F0, '0));
        send_instr(make_instr(OP_AND,   5'd16, 5'd2, 5'd3, '0, '0));
        send_instr(make_instr(OP_OR,    5'd17, 5'd1, 5'd3, '0, '0));
        send_instr(make_instr(OP_BEQ,   5'd0, 5'd0, 5'd0, 32'h8000_0000, '0));
        send_instr(make_instr(OP_BNE,   5'd1, 5'd1, 5'd0, 32'd5, '0));
        send_instr(make_instr(OP_JAL,   5'd0, 5'd0, 5'd0, '0, 26'h3FF_FFFF));
        send_instr(make_instr(OP_J,     5'd0, 5'd0, 5'd0, '0, 26'h000_0001));
        send_instr(make_instr(OP_JR,    5'd0, 5'd1, 5'd0, '0, '0));
        send_instr(make_instr(OP_ADDIU, 5'd18, 5'd31, 5'd0, 32'h8000_0000, '0));
        for (int op = 28; op < 32; op++)
            send_instr(make_instr(5'(op), 5'd1, 5'd2, 5'd3, $urandom, 26'($urandom)));
    endtask

    // ALU work, with multiply and divide, reading back HI and LO often.
    task automatic test_arith(input int count);
        logic [4:0] ops [] = '{OP_ADD, OP_ADDI, OP_ADDIU, OP_ANDI, OP_AND, OP_LUI, OP_ORI,
                               OP_OR, OP_SRL, OP_SUB, OP_SLL, OP_SLTI, OP_SLT, OP_DIV,
                               OP_MULT, OP_MFHI, OP_MFLO};
        for (int n = 0; n < count; n++)
            send_instr(make_instr(ops[$urandom_range(0, ops.size() - 1)], pick_reg(),
                                  pick_reg(), pick_reg(), pick_imm(), 26'($urandom)));
    endtask

    // Store then load back through the same base, at nearby offsets, so
    // that sub-word, unaligned and wrapping accesses read real data.
    task automatic test_memory(input int pairs);
        logic [4:0]  loads  [] = '{OP_LBU, OP_LH, OP_LW};
        logic [4:0]  stores [] = '{OP_SB, OP_SH, OP_SW};
        logic [4:0]  base;
        logic [31:0] off;
        for (int n = 0; n < pairs; n++) begin
            base = pick_reg();
            off  = ($urandom_range(0, 7) == 0) ? $urandom : 32'($urandom_range(0, 4200));
            send_instr(make_instr(stores[$urandom_range(0, 2)], pick_reg(), 5'd0, base,
                                  off, '0));
            send_instr(make_instr(loads[$urandom_range(0, 2)], pick_reg(), 5'd0, base,
                                  off + 32'($urandom_range(0, 6)) - 32'd3, '0));
        end
    endtask

    // Branches and jumps, mixed with ALU work so that compare values differ.
    task automatic test_flow(input int count);
        logic [4:0] ops [] = '{OP_BEQ, OP_BNE, OP_J, OP_JAL, OP_JR, OP_ADDI, OP_SUB};
        for (int n = 0; n < count; n++)
            send_instr(make_instr(ops[$urandom_range(0, ops.size() - 1)], pick_reg(),
                                  pick_reg(), pick_reg(), pick_imm(), 26'($urandom)));
    endtask

    // Anything at all, including the unused codes.
    task automatic test_mixed(input int count);
        for (int n = 0; n < count; n++)
            send_instr(any_instr());
    endtask

    initial begin
        i_rst_n      = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        fail_count   = 0;
        beats_sent   = 0;
        results_seen = 0;
        div_zero_seen = 0;
        quiet        = 1'b0;
        arch_pc      = '0;
        arch_hi      = '0;
        arch_lo      = '0;
        foreach (arch_gpr[i]) arch_gpr[i] = '0;
        foreach (arch_mem[i]) arch_mem[i] = '0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_arith(300);
        quiet = 1'b1;           // a stretch at full rate on both sides
        test_memory(60);
        quiet = 1'b0;
        test_memory(140);
        test_flow(200);
        quiet = 1'b1;
        test_mixed(80);
        quiet = 1'b0;
        test_mixed(220);

        in_valid <= 1'b0;
        while (owed_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Ran %0d instruction beats and checked %0d results, %0d of them divide by zero,",
                 beats_sent, results_seen, div_zero_seen);
        $display("over ALU, HI/LO, sub-word memory, branch and jump traffic with random stalls.");
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
